// File: rtl/amo_pkg.sv
// ----------------------------------------------------------------------------
// amo_pkg
// Shared types and codes of the atomic read-modify-write unit.
// ----------------------------------------------------------------------------
package amo_pkg;

   localparam int unsigned DATA_W  = 64;
   localparam int unsigned INDEX_W = 16;
   localparam int unsigned VLEN_W  = 14;
   localparam int unsigned CSR_W   = 14;

   typedef enum logic [3:0] {
      KIND_ADD     = 4'd0,
      KIND_AND     = 4'd1,
      KIND_OR      = 4'd2,
      KIND_SUB     = 4'd3,
      KIND_XOR     = 4'd4,
      KIND_XCHG    = 4'd5,
      KIND_CMPXCHG = 4'd6,
      KIND_LOAD    = 4'd7,
      KIND_STORE   = 4'd8
   } kind_type;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK     = 2'd0;
   localparam status_type STATUS_RANGE  = 2'd1;
   localparam status_type STATUS_DETACH = 2'd2;

   typedef enum logic {
      CSR_VIEW_LENGTH = 1'b0,
      CSR_DETACHED    = 1'b1
   } csr_type;

   // Request as it travels from the issue stage to the modify stage
   typedef struct packed {
      logic               access;     // element is read and may be written
      logic [3:0]         kind;
      logic [2:0]         elem_type;
      logic [2:0]         byte_sel;   // byte lane of the element in its word
      logic [DATA_W-1:0]  operand;
      logic [DATA_W-1:0]  replacement;
   } op_type;

endpackage

// File: rtl/atomic_memory_op_unit.sv
// ----------------------------------------------------------------------------
// atomic_memory_op_unit
// Atomic read-modify-write unit over a little-endian 64-bit word memory.
// ----------------------------------------------------------------------------
// Flow: an accepted request is registered into the modify stage beside its
//   memory read, then its result into the response register. The memory is
//   read in the issue cycle and written back in the modify cycle, and the next
//   request is held off until that write lands and the response register is free.
// Reset: synchronous; after reset a clearing sweep zeroes one word a cycle until all
//   MEM_WORDS words are clear; no request is accepted meanwhile (CSR writes are).
// ----------------------------------------------------------------------------
module atomic_memory_op_unit #(
   parameter int unsigned MEM_WORDS = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [143:0]               req_tdata,  // index[15:0], operand, replacement
   input  logic [6:0]                 req_tuser,  // kind[3:0], element_type[6:4]
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [63:0]                rsp_tdata,  // result_value
   output logic [1:0]                 rsp_tuser,  // status
   // configuration
   input  logic                       csr_we,
   input  logic                       csr_addr,
   input  logic [amo_pkg::CSR_W-1:0]  csr_wdata
);

   localparam int unsigned AW = $clog2(MEM_WORDS);

   // unpacked request fields
   logic [3:0]                   req_kind;
   logic [2:0]                   req_type;
   logic [amo_pkg::INDEX_W-1:0]  req_index;
   logic [amo_pkg::DATA_W-1:0]   req_operand;
   logic [amo_pkg::DATA_W-1:0]   req_replacement;

   // configuration registers
   logic [amo_pkg::VLEN_W-1:0]   view_length_ff;
   logic                         detached_ff;

   // issue stage
   logic                         accept;
   logic                         clr_busy;
   logic [1:0]                   lg;
   logic [amo_pkg::INDEX_W-1:0]  word_idx;
   logic [2:0]                   byte_sel;
   logic                         in_range;
   amo_pkg::status_type          status_in;
   amo_pkg::op_type              op_in;

   // modify stage
   logic                         s1_valid_ff;
   amo_pkg::op_type              s1_op_ff;
   amo_pkg::status_type          s1_status_ff;
   logic [AW-1:0]                s1_addr_ff;
   logic [amo_pkg::DATA_W-1:0]   rd_data;
   logic                         alu_wr_en;
   logic [amo_pkg::DATA_W-1:0]   alu_new_word;
   logic [amo_pkg::DATA_W-1:0]   alu_result;

   // response register
   logic                         rsp_valid_ff;
   logic [amo_pkg::DATA_W-1:0]   rsp_data_ff;
   amo_pkg::status_type          rsp_status_ff;

   assign req_kind        = req_tuser[3:0];
   assign req_type        = req_tuser[6:4];
   assign req_index       = req_tdata[15:0];
   assign req_operand     = req_tdata[79:16];
   assign req_replacement = req_tdata[143:80];

   // Take a request only with the modify stage empty, the sweep done, and the
   // response register free by the time this request reaches it.
   assign req_tready = ~clr_busy & ~s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign accept     = req_tvalid & req_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         view_length_ff <= '0;
         detached_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            amo_pkg::CSR_VIEW_LENGTH: view_length_ff <= csr_wdata[amo_pkg::VLEN_W-1:0];
            amo_pkg::CSR_DETACHED:    detached_ff    <= csr_wdata[0];
            default:                  ;
         endcase
      end
   end

   // Address decode: element size is 1 << lg bytes, aligned to its size,
   // so the element lies in one word; in range iff index < view length and the word exists.
   always_comb begin
      lg = req_type[2:1];
      case (lg)
         2'd0: begin
            word_idx = req_index >> 3;
            byte_sel = req_index[2:0];
         end
         2'd1: begin
            word_idx = req_index >> 2;
            byte_sel = {req_index[1:0], 1'b0};
         end
         2'd2: begin
            word_idx = req_index >> 1;
            byte_sel = {req_index[0], 2'b00};
         end
         default: begin
            word_idx = req_index;
            byte_sel = 3'b000;
         end
      endcase
      in_range = (req_index < {2'b00, view_length_ff}) &&
                 (32'(word_idx) < 32'(MEM_WORDS));

      // unused kinds win over a detached buffer, which wins over the range check
      op_in.access = 1'b0;
      if (req_kind > amo_pkg::KIND_STORE) begin
         status_in = amo_pkg::STATUS_OK;
      end else if (detached_ff) begin
         status_in = amo_pkg::STATUS_DETACH;
      end else if (!in_range) begin
         status_in = amo_pkg::STATUS_RANGE;
      end else begin
         status_in    = amo_pkg::STATUS_OK;
         op_in.access = 1'b1;
      end
      op_in.kind        = req_kind;
      op_in.elem_type   = req_type;
      op_in.byte_sel    = byte_sel;
      op_in.operand     = req_operand;
      op_in.replacement = req_replacement;
   end

   amo_mem #(
      .MEM_WORDS (MEM_WORDS),
      .AW        (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (AW'(word_idx)),
      .rd_data  (rd_data),
      .wr_en    (s1_valid_ff & alu_wr_en),
      .wr_addr  (s1_addr_ff),
      .wr_data  (alu_new_word),
      .clr_busy (clr_busy)
   );

   // hold the request beside its memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_op_ff     <= op_in;
         s1_status_ff <= status_in;
         s1_addr_ff   <= AW'(word_idx);
      end
   end

   amo_alu u_alu (
      .op       (s1_op_ff),
      .old_word (rd_data),
      .wr_en    (alu_wr_en),
      .new_word (alu_new_word),
      .result   (alu_result)
   );

   // response register: load from the modify stage, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_valid_ff) begin
         rsp_data_ff   <= alu_result;
         rsp_status_ff <= s1_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// File: rtl/amo_mem.sv
// ----------------------------------------------------------------------------
// amo_mem
// Word memory with a registered read port, one write port and a clearing
// sweep after reset.
// ----------------------------------------------------------------------------
module amo_mem #(
   parameter int unsigned MEM_WORDS = 1024,
   parameter int unsigned AW        = $clog2(MEM_WORDS)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic [amo_pkg::DATA_W-1:0] rd_data,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [amo_pkg::DATA_W-1:0] wr_data,
   output logic                       clr_busy
);

   logic [amo_pkg::DATA_W-1:0] mem_ff [MEM_WORDS];
   logic [amo_pkg::DATA_W-1:0] rd_data_ff;
   logic [AW-1:0]              clr_cnt_ff, clr_cnt_in;
   logic                       clr_busy_ff, clr_busy_in;
   logic                       we;
   logic [AW-1:0]              wa;
   logic [amo_pkg::DATA_W-1:0] wd;

   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         if (clr_cnt_ff == AW'(MEM_WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // sweep owns the write port until it is done
   always_comb begin
      we = clr_busy_ff | wr_en;
      wa = clr_busy_ff ? clr_cnt_ff : wr_addr;
      wd = clr_busy_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clr_busy = clr_busy_ff;

endmodule

// File: rtl/amo_alu.sv
// ----------------------------------------------------------------------------
// amo_alu
// Element extract, modify and merge for one read-modify-write.
// ----------------------------------------------------------------------------
module amo_alu (
   input  amo_pkg::op_type             op,
   input  logic [amo_pkg::DATA_W-1:0]  old_word,
   output logic                        wr_en,
   output logic [amo_pkg::DATA_W-1:0]  new_word,
   output logic [amo_pkg::DATA_W-1:0]  result
);

   logic [1:0]                 lg;
   logic                       sgn;
   logic [5:0]                 sh;
   logic [amo_pkg::DATA_W-1:0] mask;
   logic [amo_pkg::DATA_W-1:0] old;
   logic [amo_pkg::DATA_W-1:0] nv;
   logic [amo_pkg::DATA_W-1:0] ext;
   logic                       upd;

   always_comb begin
      lg  = op.elem_type[2:1];
      sgn = ~op.elem_type[0];
      sh  = {op.byte_sel, 3'b000};
      case (lg)
         2'd0:    mask = 64'h0000_0000_0000_00FF;
         2'd1:    mask = 64'h0000_0000_0000_FFFF;
         2'd2:    mask = 64'h0000_0000_FFFF_FFFF;
         default: mask = '1;
      endcase
      old = (old_word >> sh) & mask;

      // extend the old element for the return value
      case (lg)
         2'd0:    ext = {{56{sgn & old[7]}},  old[7:0]};
         2'd1:    ext = {{48{sgn & old[15]}}, old[15:0]};
         2'd2:    ext = {{32{sgn & old[31]}}, old[31:0]};
         default: ext = old;
      endcase

      upd = 1'b1;
      nv  = op.operand;
      case (op.kind)
         amo_pkg::KIND_ADD:     nv = old + op.operand;
         amo_pkg::KIND_AND:     nv = old & op.operand;
         amo_pkg::KIND_OR:      nv = old | op.operand;
         amo_pkg::KIND_SUB:     nv = old - op.operand;
         amo_pkg::KIND_XOR:     nv = old ^ op.operand;
         amo_pkg::KIND_XCHG:    nv = op.operand;
         amo_pkg::KIND_CMPXCHG: begin
            nv  = op.replacement;
            upd = (old == (op.operand & mask));
         end
         amo_pkg::KIND_LOAD:    upd = 1'b0;
         amo_pkg::KIND_STORE:   nv = op.operand;
         default:               upd = 1'b0;
      endcase

      wr_en    = op.access & upd;
      new_word = (old_word & ~(mask << sh)) | ((nv & mask) << sh);

      if (!op.access) begin
         result = '0;
      end else if (op.kind == amo_pkg::KIND_STORE) begin
         result = op.operand;
      end else begin
         result = ext;
      end
   end

endmodule
